FILE: rtl/multi_width_byte_stack_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte-addressed operand stack
// Shared property forms, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_WIDTH_BYTE_STACK_ASSERT_SVH
`define MULTI_WIDTH_BYTE_STACK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MWBS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MWBS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/mwbs_pkg.sv
// ----------------------------------------------------------------------------
// mwbs_pkg
// Types, constants and helpers shared by the operand stack modules.
// ----------------------------------------------------------------------------
package mwbs_pkg;

   localparam int FILL_W              = 13;
   localparam int FILL_MAX            = (2 ** FILL_W) - 1;
   localparam int LANES               = 8;
   localparam int STACK_BYTES_DEFAULT = 4096;
   localparam logic [FILL_W-1:0] CAPACITY_RESET = 13'd4096;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   localparam logic [1:0] WIDTH_1 = 2'd0;
   localparam logic [1:0] WIDTH_2 = 2'd1;
   localparam logic [1:0] WIDTH_4 = 2'd2;
   localparam logic [1:0] WIDTH_8 = 2'd3;

   typedef struct packed {
      logic        req_type;
      logic [1:0]  width_code;
      logic [63:0] push_value;
   } req_item_type;

   typedef struct packed {
      logic [63:0]       pop_value;
      logic [1:0]        status;
      logic [FILL_W-1:0] bytes_in_use;
   } rsp_item_type;

   function automatic logic [3:0] width_bytes(input logic [1:0] code);
      logic [3:0] w;
      unique case (code)
         WIDTH_1: w = 4'd1;
         WIDTH_2: w = 4'd2;
         WIDTH_4: w = 4'd4;
         WIDTH_8: w = 4'd8;
         default: w = 4'd1;
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/mwbs_ram.sv
// ----------------------------------------------------------------------------
// mwbs_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module mwbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/mwbs_lanes.sv
// ----------------------------------------------------------------------------
// mwbs_lanes
// Maps an unaligned byte access onto eight byte-lane banks: row, enable
// and write byte for each lane.
// ----------------------------------------------------------------------------
module mwbs_lanes
   import mwbs_pkg::*;
#(
   parameter int ROW_W = 9
) (
   input  logic [FILL_W-1:0] base,
   input  logic [1:0]        width_code,
   input  logic [63:0]       push_value,
   output logic [LANES-1:0]  lane_used,
   output logic [ROW_W-1:0]  lane_row [LANES],
   output logic [7:0]        lane_wdata [LANES]
);

   logic [3:0] w;

   assign w = width_bytes(width_code);

   // Byte i of the access lands in lane (base + i) mod 8. Lanes below the
   // starting lane hold the bytes that spill into the next row.
   always_comb begin
      logic [2:0]        off;
      logic [FILL_W-4:0] row_sum;
      for (int l = 0; l < LANES; l++) begin
         off            = 3'(l) - base[2:0];
         lane_used[l]   = {1'b0, off} < w;
         row_sum        = base[FILL_W-1:3] + {{(FILL_W-4){1'b0}}, (3'(l) < base[2:0])};
         lane_row[l]    = ROW_W'(row_sum);
         lane_wdata[l]  = push_value[{off, 3'b000} +: 8];
      end
   end

endmodule

FILE: rtl/multi_width_byte_stack.sv
// ----------------------------------------------------------------------------
// multi_width_byte_stack
// Byte-addressed operand stack with 1, 2, 4 and 8 byte pushes and pops,
// stored little-endian at unaligned offsets in eight byte-lane banks.
// ----------------------------------------------------------------------------
//   Channel | Direction | Handshake         | Payload
//   req     | in        | req_valid/ready   | req_item_type
//   rsp     | out       | rsp_valid/ready   | rsp_item_type
//   csr     | in        | csr_write_en      | capacity in bytes (13 bits)
//
// An item is checked and its banks are read or written in the cycle it is
// accepted; the result is assembled from the bank read data in the next
// cycle and is registered onto rsp once rsp can take it. With rsp drained,
// one item is taken every cycle. A stalled rsp holds one result and one
// pending item, then req_ready drops. Reset clears the fill count and
// restores the capacity; the bank contents need no clearing.
// ----------------------------------------------------------------------------
module multi_width_byte_stack
   import mwbs_pkg::*;
#(
   parameter int STACK_BYTES = STACK_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_en,
   input  logic [FILL_W-1:0] csr_write_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_item_type      req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_item_type      rsp_payload
);

   localparam int BANK_DEPTH = (STACK_BYTES + LANES - 1) / LANES;
   localparam int ROW_W      = $clog2(BANK_DEPTH);
   localparam logic [FILL_W-1:0] STACK_LIM =
      FILL_W'((STACK_BYTES < FILL_MAX) ? STACK_BYTES : FILL_MAX);

   typedef struct packed {
      logic              read;
      logic [1:0]        status;
      logic [FILL_W-1:0] fill;
      logic [2:0]        base_lo;
      logic [1:0]        width_code;
   } pend_type;

   logic [FILL_W-1:0] capacity_ff, capacity_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              pend_valid_ff, pend_valid_in;
   pend_type          pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_ff, rsp_in;

   logic              req_fire;
   logic              pend_move;
   logic              is_pop;
   logic [3:0]        w;
   logic [FILL_W-1:0] cap_eff;
   logic              push_ok;
   logic              pop_ok;
   logic [FILL_W-1:0] base;
   logic [LANES-1:0]  lane_used;
   logic [ROW_W-1:0]  lane_row [LANES];
   logic [7:0]        lane_wdata [LANES];
   logic [7:0]        lane_rdata [LANES];
   logic [63:0]       pop_assembled;
   logic [3:0]        pend_w;

   assign pend_move = pend_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !reset && (!pend_valid_ff || pend_move);
   assign req_fire  = req_valid && req_ready;

   assign is_pop  = (req_payload.req_type == REQ_POP);
   assign w       = width_bytes(req_payload.width_code);
   assign cap_eff = (capacity_ff > STACK_LIM) ? STACK_LIM : capacity_ff;
   assign push_ok = ({1'b0, fill_ff} + {{(FILL_W-3){1'b0}}, w}) < {1'b0, cap_eff};
   assign pop_ok  = fill_ff >= {{(FILL_W-4){1'b0}}, w};
   assign base    = is_pop ? (fill_ff - {{(FILL_W-4){1'b0}}, w}) : fill_ff;

   mwbs_lanes #(
      .ROW_W (ROW_W)
   ) u_lanes (
      .base       (base),
      .width_code (req_payload.width_code),
      .push_value (req_payload.push_value),
      .lane_used  (lane_used),
      .lane_row   (lane_row),
      .lane_wdata (lane_wdata)
   );

   for (genvar g = 0; g < LANES; g++) begin : g_bank
      mwbs_ram #(
         .WIDTH (8),
         .DEPTH (BANK_DEPTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (req_fire && !is_pop && push_ok && lane_used[g]),
         .wr_addr (lane_row[g]),
         .wr_data (lane_wdata[g]),
         .rd_en   (req_fire && is_pop && pop_ok && lane_used[g]),
         .rd_addr (lane_row[g]),
         .rd_data (lane_rdata[g])
      );
   end

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_write_en) begin
         capacity_in = csr_write_data;
      end
   end

   always_comb begin
      fill_in          = fill_ff;
      pend_valid_in    = pend_valid_ff && !pend_move;
      pend_in          = pend_ff;
      if (req_fire) begin
         pend_valid_in      = 1'b1;
         pend_in.read       = 1'b0;
         pend_in.base_lo    = base[2:0];
         pend_in.width_code = req_payload.width_code;
         if (!is_pop && push_ok) begin
            fill_in        = fill_ff + {{(FILL_W-4){1'b0}}, w};
            pend_in.status = STATUS_OK;
         end else if (is_pop && pop_ok) begin
            fill_in        = base;
            pend_in.read   = 1'b1;
            pend_in.status = STATUS_OK;
         end else if (is_pop) begin
            pend_in.status = STATUS_UNDERFLOW;
         end else begin
            pend_in.status = STATUS_OVERFLOW;
         end
         pend_in.fill = fill_in;
      end
   end

   assign pend_w = width_bytes(pend_ff.width_code);

   // Byte i of the popped value comes from lane (base + i) mod 8.
   always_comb begin
      logic [2:0] lane;
      for (int i = 0; i < LANES; i++) begin
         lane = pend_ff.base_lo + 3'(i);
         pop_assembled[8*i +: 8] = (pend_ff.read && (4'(i) < pend_w)) ? lane_rdata[lane]
                                                                     : 8'h00;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (pend_move) begin
         rsp_valid_in        = 1'b1;
         rsp_in.pop_value    = pop_assembled;
         rsp_in.status       = pend_ff.status;
         rsp_in.bytes_in_use = pend_ff.fill;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= CAPACITY_RESET;
         fill_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         capacity_ff   <= capacity_in;
         fill_ff       <= fill_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: rtl/mwbs_checker.sv
// ----------------------------------------------------------------------------
// mwbs_checker
// Port-level checks on the operand stack, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_width_byte_stack_assert.svh"

module mwbs_checker
   import mwbs_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_payload
);

   logic [1:0]        outst_ff, outst_in;
   logic [FILL_W-1:0] prev_fill_ff, prev_fill_in;
   logic              in_fire;
   logic              out_fire;

   assign in_fire  = req_valid && req_ready;
   assign out_fire = rsp_valid && rsp_ready;

   assign outst_in     = outst_ff + {1'b0, in_fire} - {1'b0, out_fire};
   assign prev_fill_in = out_fire ? rsp_payload.bytes_in_use : prev_fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         outst_ff     <= '0;
         prev_fill_ff <= '0;
      end else begin
         outst_ff     <= outst_in;
         prev_fill_ff <= prev_fill_in;
      end
   end

   `MWBS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "rsp item changed while stalled")

   // Every result belongs to an item that was accepted earlier.
   `MWBS_ASSERT_NOW(a_no_spurious_rsp, rsp_valid, outst_ff != 2'd0, "result without an accepted item")

   // A rejected item leaves the fill where the previous result left it.
   `MWBS_ASSERT_NOW(a_error_keeps_fill, out_fire && (rsp_payload.status != STATUS_OK), rsp_payload.bytes_in_use == prev_fill_ff, "fill changed on a rejected item")

   // A successful push or pop always moves the fill.
   `MWBS_ASSERT_NOW(a_ok_moves_fill, out_fire && (rsp_payload.status == STATUS_OK), rsp_payload.bytes_in_use != prev_fill_ff, "fill unchanged on a successful item")

endmodule

bind multi_width_byte_stack mwbs_checker u_checker (.*);

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Operand stack testbench
// Drives random and directed push and pop requests with random idling on
// both channels, predicts every result from a shadow copy of the stack, and
// compares each returned item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
   import mwbs_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AT     = 120;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_en = 1'b0;
   logic [FILL_W-1:0] csr_write_data = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_item_type      req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_item_type      rsp_payload;

   // Shadow copy of the stack and its capacity setting.
   logic [FILL_W-1:0] capacity_setting = CAPACITY_RESET;
   int unsigned       shadow_fill = 0;
   logic [7:0]        shadow_bytes [0:STACK_BYTES_DEFAULT-1];

   req_item_type request_queue [$];
   rsp_item_type outcome_queue [$];

   int  fail_count   = 0;
   int  results_seen = 0;
   int  cycle_count  = 0;
   int  send_gap     = 0;
   int  stall_gap    = 0;
   int  hold_left    = 0;
   bit  hold_used    = 1'b0;
   bit  calm         = 1'b0;

   multi_width_byte_stack dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Applies one request to the shadow stack and returns the item it yields.
   function automatic rsp_item_type stack_outcome(input req_item_type item);
      rsp_item_type result;
      int unsigned  nbytes;
      int unsigned  limit;
      int unsigned  i;
      result = '0;
      result.status = STATUS_OK;
      nbytes = 1 << item.width_code;
      limit = (capacity_setting > STACK_BYTES_DEFAULT) ? STACK_BYTES_DEFAULT
                                                         : capacity_setting;
      if (item.req_type == REQ_PUSH) begin
         // The bound is strict, so the top byte of the capacity stays empty.
         if (shadow_fill + nbytes < limit) begin
            for (i = 0; i < nbytes; i++)
               shadow_bytes[shadow_fill + i] = item.push_value[8*i +: 8];
            shadow_fill = shadow_fill + nbytes;
         end else begin
            result.status = STATUS_OVERFLOW;
         end
      end else begin
         if (shadow_fill >= nbytes) begin
            shadow_fill = shadow_fill - nbytes;
            for (i = 0; i < nbytes; i++)
               result.pop_value[8*i +: 8] = shadow_bytes[shadow_fill + i];
         end else begin
            result.status = STATUS_UNDERFLOW;
         end
      end
      result.bytes_in_use = shadow_fill[FILL_W-1:0];
      return result;
   endfunction

   task automatic add_request(input logic kind, input logic [1:0] code,
                              input logic [63:0] value);
      req_item_type item;
      item.req_type   = kind;
      item.width_code = code;
      item.push_value = value;
      request_queue.push_back(item);
   endtask

   task automatic add_random(input int count, input int push_pct, input int wide_pct);
      req_item_type item;
      repeat (count) begin
         item.req_type = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
         if ($urandom_range(0, 99) < wide_pct)
            item.width_code = WIDTH_8;
         else
            item.width_code = 2'($urandom_range(0, 3));
         item.push_value = {$urandom, $urandom};
         request_queue.push_back(item);
      end
   endtask

   // Waits until every queued item has been taken and every result returned.
   task automatic drain;
      do
         @(negedge clock);
      while (request_queue.size() != 0 || req_valid || outcome_queue.size() != 0);
   endtask

   task automatic set_capacity(input logic [FILL_W-1:0] value);
      @(posedge clock);
      csr_write_en     <= 1'b1;
      csr_write_data   <= value;
      capacity_setting = value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   always @(posedge clock) begin : driver
      logic offer;
      offer = req_valid;
      if (reset) begin
         offer = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            outcome_queue.push_back(stack_outcome(req_payload));
            offer = 1'b0;
         end
         if (calm)
            send_gap = 0;
         if (!offer) begin
            if (send_gap == 0 && !calm && $urandom_range(0, 99) < 6)
               send_gap = $urandom_range(1, 17);
            if (send_gap > 0) begin
               send_gap--;
            end else if (request_queue.size() > 0) begin
               req_payload <= request_queue.pop_front();
               offer = 1'b1;
            end
         end
      end
      req_valid <= offer;
   end

   always @(posedge clock) begin : monitor
      logic         ready_next;
      rsp_item_type want;
      ready_next = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (outcome_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result item: pop_value=%h status=%0d fill=%0d",
                           rsp_payload.pop_value, rsp_payload.status,
                           rsp_payload.bytes_in_use);
            end else begin
               want = outcome_queue.pop_front();
               if (rsp_payload.pop_value !== want.pop_value ||
                   rsp_payload.status !== want.status ||
                   rsp_payload.bytes_in_use !== want.bytes_in_use) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"mismatch: expected pop_value=%h status=%0d fill=%0d,",
                               " got pop_value=%h status=%0d fill=%0d"},
                              want.pop_value, want.status, want.bytes_in_use,
                              rsp_payload.pop_value, rsp_payload.status,
                              rsp_payload.bytes_in_use);
               end
            end
         end
         if (hold_left != 0) begin
            ready_next = 1'b0;
         end else if (calm) begin
            stall_gap  = 0;
            ready_next = 1'b1;
         end else begin
            if (stall_gap == 0 && $urandom_range(0, 99) < 6)
               stall_gap = $urandom_range(1, 17);
            if (stall_gap > 0) begin
               stall_gap--;
               ready_next = 1'b0;
            end else begin
               ready_next = 1'b1;
            end
         end
      end
      rsp_ready <= ready_next;
   end

   // One long hold-off on the result side, so the block backs up into req.
   always @(posedge clock) begin : long_hold
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_used && results_seen == HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset capacity.
      add_request(REQ_POP,  WIDTH_1, 64'h0);
      add_request(REQ_POP,  WIDTH_8, 64'hFFFF_FFFF_FFFF_FFFF);
      add_request(REQ_PUSH, WIDTH_1, 64'hFFFF_FFFF_FFFF_FFFF);
      add_request(REQ_PUSH, WIDTH_2, 64'h5A5A_5A5A_5A5A_A55A);
      add_request(REQ_PUSH, WIDTH_4, 64'hFFFF_FFFF_FFFF_FFFF);
      add_request(REQ_PUSH, WIDTH_8, 64'h0123_4567_89AB_CDEF);
      add_request(REQ_POP,  WIDTH_8, 64'hFFFF_FFFF_FFFF_FFFF);
      add_request(REQ_POP,  WIDTH_4, 64'h0);
      add_request(REQ_POP,  WIDTH_2, 64'hAAAA_AAAA_AAAA_AAAA);
      add_request(REQ_POP,  WIDTH_1, 64'h0);
      add_request(REQ_POP,  WIDTH_2, 64'h0);
      add_request(REQ_POP,  WIDTH_4, 64'h0);
      add_request(REQ_PUSH, WIDTH_8, 64'h8000_0000_0000_0001);
      add_request(REQ_PUSH, WIDTH_8, 64'h0);
      // Unaligned pops across the two pushed words.
      add_request(REQ_POP,  WIDTH_1, 64'h0);
      add_request(REQ_POP,  WIDTH_2, 64'h0);
      add_request(REQ_POP,  WIDTH_4, 64'h0);
      add_request(REQ_POP,  WIDTH_8, 64'h5555_5555_5555_5555);
      add_request(REQ_POP,  WIDTH_1, 64'h0);
      add_request(REQ_PUSH, WIDTH_1, 64'h0);
      add_request(REQ_POP,  WIDTH_1, 64'h0);
      add_request(REQ_POP,  WIDTH_8, 64'h0);
      drain();

      // A capacity of zero or one byte makes every push overflow.
      set_capacity('0);
      add_random(20, 60, 0);
      drain();
      set_capacity(13'd1);
      add_random(15, 60, 0);
      drain();

      // Capacity above the store size; climb towards the top of the store, whose last byte stays empty.
      set_capacity(13'h1FFF);
      add_random(530, 99, 93);
      drain();

      // Capacity lowered below the fill: pushes overflow while pops drain it.
      set_capacity(13'd40);
      add_random(400, 2, 95);
      drain();

      calm = 1'b1;
      set_capacity(13'd97);
      add_random(80, 45, 10);
      drain();
      repeat (10) @(negedge clock);

      if (fail_count == 0 && outcome_queue.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: multi_width_byte_stack.f
+incdir+rtl
rtl/mwbs_pkg.sv
rtl/mwbs_ram.sv
rtl/mwbs_lanes.sv
rtl/multi_width_byte_stack.sv
rtl/mwbs_checker.sv
sim/testbench.sv
